[rtl/lir_pkg.sv]
// Shared types and constants of the linear interpolation resampler.
package lir_pkg;

   localparam int STEP_BITS     = 20;
   localparam int CHAN_BITS     = 2;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 20;

   localparam logic [STEP_BITS-1:0] STEP_RESET = 20'd65536;
   localparam logic [CHAN_BITS-1:0] CHAN_RESET = 2'd2;
   localparam logic [CHAN_BITS-1:0] CHAN_MONO  = 2'd1;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_STEP_RATIO    = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1
   } csr_addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INTERP_CHECK,
      ST_CALC,
      ST_EMIT,
      ST_COMMIT,
      ST_FLUSH_CHECK,
      ST_FLUSH_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic last;
   } emit_type;

endpackage

[rtl/lir_lerp.sv]
// Bit-serial interpolation lane: base + floor((target - base) * frac / 2^FRAC_BITS).
module lir_lerp #(
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [FRAC_BITS-1:0]   frac,
   input  logic [SAMPLE_BITS-1:0] base,
   input  logic [SAMPLE_BITS-1:0] target,
   output logic                   done,
   output logic [SAMPLE_BITS-1:0] result
);
   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int ACC_BITS  = SAMPLE_BITS + 2;
   localparam int CNT_BITS  = $clog2(FRAC_BITS + 1);

   logic [DIFF_BITS-1:0] diff_ff, diff_in;
   logic [ACC_BITS-1:0]  acc_ff, acc_in;
   logic [FRAC_BITS-1:0] frac_sh_ff, frac_sh_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [ACC_BITS-1:0]  addend;
   logic [ACC_BITS-1:0]  sum;

   // one multiplier bit per cycle, LSB first; the right shift keeps the floor exact
   always_comb begin
      addend     = frac_sh_ff[0] ? {diff_ff[DIFF_BITS-1], diff_ff} : '0;
      sum        = acc_ff + addend;
      diff_in    = diff_ff;
      acc_in     = acc_ff;
      frac_sh_in = frac_sh_ff;
      cnt_in     = cnt_ff;
      if (start) begin
         diff_in    = {target[SAMPLE_BITS-1], target} - {base[SAMPLE_BITS-1], base};
         acc_in     = '0;
         frac_sh_in = frac;
         cnt_in     = CNT_BITS'(FRAC_BITS);
      end else if (cnt_ff != '0) begin
         acc_in     = {sum[ACC_BITS-1], sum[ACC_BITS-1:1]};
         frac_sh_in = frac_sh_ff >> 1;
         cnt_in     = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      diff_ff    <= diff_in;
      acc_ff     <= acc_in;
      frac_sh_ff <= frac_sh_in;
   end

   assign done   = (cnt_ff == '0);
   assign result = base + acc_ff[SAMPLE_BITS-1:0];

endmodule

[rtl/lir_seq.sv]
// Frame sequencer: read position, held frame, priming and end-of-stream flush.
module lir_seq #(
   parameter int SAMPLE_BITS  = 24,
   parameter int FRAC_BITS    = 16,
   parameter int MAX_UPSAMPLE = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [SAMPLE_BITS-1:0]         req_left,
   input  logic [SAMPLE_BITS-1:0]         req_right,
   input  logic                           req_eos,
   input  logic [lir_pkg::STEP_BITS-1:0]  step_ratio,
   input  logic [lir_pkg::CHAN_BITS-1:0]  channel_count,
   input  logic                           slot_free,
   output lir_pkg::emit_type              emit,
   output logic [SAMPLE_BITS-1:0]         out_left,
   output logic [SAMPLE_BITS-1:0]         out_right
);
   import lir_pkg::*;

   localparam int WIDE_BITS = (STEP_BITS > FRAC_BITS + 1) ? STEP_BITS : FRAC_BITS + 1;
   localparam int POS_BITS  = WIDE_BITS + 1;
   localparam int MIN_STEP  = ((1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
   localparam logic [POS_BITS-1:0] ONE_POS  = POS_BITS'(1) << FRAC_BITS;
   localparam logic [POS_BITS-1:0] TWO_POS  = POS_BITS'(2) << FRAC_BITS;
   localparam logic [POS_BITS-1:0] MIN_POS  = POS_BITS'(MIN_STEP);

   state_type state_ff, state_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic                   primed_ff, primed_in;
   logic [SAMPLE_BITS-1:0] held_l_ff, held_l_in, held_r_ff, held_r_in;
   logic [SAMPLE_BITS-1:0] new_l_ff, new_l_in, new_r_ff, new_r_in;
   logic                   eos_ff, eos_in, mono_ff, mono_in;
   logic [POS_BITS-1:0]    step_ff, step_in;

   logic [POS_BITS-1:0]    step_ext;
   logic [POS_BITS-1:0]    pos_next;
   logic                   below_one, next_ge_one, next_ge_two;
   logic                   lerp_start, done_l, done_r;
   logic [SAMPLE_BITS-1:0] lerp_l, lerp_r;

   assign step_ext    = POS_BITS'(step_ratio);
   assign pos_next    = pos_ff + step_ff;
   assign below_one   = (pos_ff[POS_BITS-1:FRAC_BITS] == '0);
   assign next_ge_one = (pos_next[POS_BITS-1:FRAC_BITS] != '0);
   assign next_ge_two = (pos_next >= TWO_POS);

   lir_lerp #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lerp_l (
      .clock  (clock),
      .reset  (reset),
      .start  (lerp_start),
      .frac   (pos_ff[FRAC_BITS-1:0]),
      .base   (held_l_ff),
      .target (new_l_ff),
      .done   (done_l),
      .result (lerp_l)
   );

   lir_lerp #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lerp_r (
      .clock  (clock),
      .reset  (reset),
      .start  (lerp_start),
      .frac   (pos_ff[FRAC_BITS-1:0]),
      .base   (held_r_ff),
      .target (new_r_ff),
      .done   (done_r),
      .result (lerp_r)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:         if (req_valid) state_in = primed_ff ? ST_INTERP_CHECK : ST_COMMIT;
         ST_INTERP_CHECK: state_in = below_one ? ST_CALC : ST_COMMIT;
         ST_CALC:         if (done_l && done_r) state_in = ST_EMIT;
         ST_EMIT:         if (slot_free) state_in = ST_INTERP_CHECK;
         ST_COMMIT:       state_in = eos_ff ? ST_FLUSH_CHECK : ST_IDLE;
         ST_FLUSH_CHECK:  state_in = below_one ? ST_FLUSH_EMIT : ST_IDLE;
         ST_FLUSH_EMIT:   if (slot_free) state_in = ST_FLUSH_CHECK;
         default:         state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      lerp_start = (state_ff == ST_INTERP_CHECK) && below_one;
      emit.load  = ((state_ff == ST_EMIT) || (state_ff == ST_FLUSH_EMIT)) && slot_free;
      if (state_ff == ST_EMIT) begin
         emit.last = next_ge_one && (!eos_ff || next_ge_two);
         out_left  = lerp_l;
         out_right = mono_ff ? '0 : lerp_r;
      end else begin
         emit.last = next_ge_one;
         out_left  = new_l_ff;
         out_right = new_r_ff;
      end
   end

   // datapath
   always_comb begin
      pos_in    = pos_ff;
      primed_in = primed_ff;
      held_l_in = held_l_ff;
      held_r_in = held_r_ff;
      new_l_in  = new_l_ff;
      new_r_in  = new_r_ff;
      eos_in    = eos_ff;
      mono_in   = mono_ff;
      step_in   = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mono_in  = (channel_count == CHAN_MONO);
               new_l_in = req_left;
               new_r_in = (channel_count == CHAN_MONO) ? '0 : req_right;
               eos_in   = req_eos;
               step_in  = (step_ext < MIN_POS) ? MIN_POS : step_ext;
            end
         end
         ST_INTERP_CHECK: begin
            if (!below_one) pos_in = pos_ff - ONE_POS;
         end
         ST_EMIT, ST_FLUSH_EMIT: begin
            if (slot_free) pos_in = pos_next;
         end
         ST_COMMIT: begin
            held_l_in = new_l_ff;
            held_r_in = new_r_ff;
            primed_in = 1'b1;
         end
         ST_FLUSH_CHECK: begin
            if (!below_one) begin
               pos_in    = '0;
               held_l_in = '0;
               held_r_in = '0;
               primed_in = 1'b0;
            end
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         primed_ff <= 1'b0;
         held_l_ff <= '0;
         held_r_ff <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         primed_ff <= primed_in;
         held_l_ff <= held_l_in;
         held_r_ff <= held_r_in;
      end
      new_l_ff <= new_l_in;
      new_r_ff <= new_r_in;
      eos_ff   <= eos_in;
      mono_ff  <= mono_in;
      step_ff  <= step_in;
   end

endmodule

[rtl/linear_interp_resampler.sv]
// Top level of the linear interpolation sample rate converter.
//
//  channel  | direction | tdata (low bit up)              | tlast          | tuser
//  req_     | in        | left_sample, right_sample, pad  | end_of_stream  | -
//  rsp_     | out       | left_out, right_out, pad        | last_of_run    | -
//  csr_     | in        | index 0 step_ratio, index 1 channel_count (write only)
//
// Each output sample passes a check, a bit-serial multiply and an emit step; the
// interpolation multiply runs one fraction bit per cycle, in two lanes (left,
// right) at once. Each flush output after end of stream passes a check and an
// emit step. Reset is synchronous and clears the held frame, the read position
// and the primed flag; no clearing pass is needed.
// A finished result waits in the output register, so a stalled rsp_ side holds
// only the sequencer step that wants to load the next result.
module linear_interp_resampler #(
   parameter int SAMPLE_BITS  = 24,
   parameter int FRAC_BITS    = 16,
   parameter int MAX_UPSAMPLE = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request side
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,  // left_sample, right_sample
   input  logic                              req_tlast,   // end_of_stream
   // result side
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,  // left_out, right_out
   output logic                              rsp_tlast,   // last_of_run
   // configuration
   input  logic                              csr_wr_en,
   input  logic [lir_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [lir_pkg::CSR_DATA_BITS-1:0] csr_wr_data
);
   import lir_pkg::*;

   localparam int TDATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;

   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [CHAN_BITS-1:0]   chan_ff, chan_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   slot_free;
   emit_type               emit;
   logic [SAMPLE_BITS-1:0] out_left, out_right;

   // output slot takes a new result when empty or drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   lir_seq #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .FRAC_BITS    (FRAC_BITS),
      .MAX_UPSAMPLE (MAX_UPSAMPLE)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_left      (req_tdata[SAMPLE_BITS-1:0]),
      .req_right     (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .req_eos       (req_tlast),
      .step_ratio    (step_ff),
      .channel_count (chan_ff),
      .slot_free     (slot_free),
      .emit          (emit),
      .out_left      (out_left),
      .out_right     (out_right)
   );

   // configuration writes; ignore indexes beyond the register list
   always_comb begin
      step_in = step_ff;
      chan_in = chan_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_STEP_RATIO: begin
               step_in = csr_wr_data[STEP_BITS-1:0];
            end
            CSR_CHANNEL_COUNT: begin
               chan_in = csr_wr_data[CHAN_BITS-1:0];
            end
            default: begin
               step_in = step_ff;
            end
         endcase
      end
   end

   // output register: load a new request result, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
         rsp_left_in  = out_left;
         rsp_right_in = out_right;
         rsp_last_in  = emit.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         chan_ff      <= CHAN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'({rsp_right_ff, rsp_left_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule

[tb/sv/lir_tb_pkg.sv]
`timescale 1ns / 100ps
// Constants, output record and scoreboard class for the resampler testbench.
package lir_tb_pkg;
   import lir_pkg::*;

   localparam int SAMPLE_BITS  = 24;
   localparam int FRAC_BITS    = 16;
   localparam int MAX_UPSAMPLE = 8;

   localparam longint unsigned ONE_POS  = 64'd1 << FRAC_BITS;
   localparam longint unsigned MIN_STEP = (ONE_POS + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;

   // register indexes with no register behind them
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_HIGH = 2'd3;

   localparam logic [CHAN_BITS-1:0] CHAN_STEREO    = 2'd2;
   localparam logic [CHAN_BITS-1:0] CHAN_ODD_ZERO  = 2'd0;
   localparam logic [CHAN_BITS-1:0] CHAN_ODD_THREE = 2'd3;

   localparam logic [STEP_BITS-1:0] STEP_LOW      = 20'd8192;
   localparam logic [STEP_BITS-1:0] STEP_HIGH     = 20'd524288;
   localparam logic [STEP_BITS-1:0] STEP_UNITY    = 20'd65536;
   localparam logic [STEP_BITS-1:0] STEP_ALL_ONES = 20'hFFFFF;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7F_FFFF;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h80_0000;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] right;
      logic                   run_end;
   } out_frame_type;

   class resample_scoreboard;
      logic [STEP_BITS-1:0] step_ratio;
      logic [CHAN_BITS-1:0] channel_count;
      longint               held_left;
      longint               held_right;
      longint unsigned      read_position;
      bit                   primed;
      out_frame_type        expected_outputs[$];
      int                   mismatches;

      function new();
         step_ratio    = STEP_RESET;
         channel_count = CHAN_RESET;
         held_left     = 0;
         held_right    = 0;
         read_position = 0;
         primed        = 1'b0;
         mismatches    = 0;
      endfunction

      function int outstanding();
         return expected_outputs.size();
      endfunction

      function void write_register(logic [CSR_ADDR_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_STEP_RATIO:    step_ratio = value[STEP_BITS-1:0];
            CSR_CHANNEL_COUNT: channel_count = value[CHAN_BITS-1:0];
            default: ;
         endcase
      endfunction

      // held + floor((next - held) * pos / 2^FRAC_BITS)
      function longint interpolate(longint held, longint next, longint unsigned pos);
         longint prod;
         prod = (next - held) * longint'(pos);
         return held + (prod >>> FRAC_BITS);
      endfunction

      function void push_output(longint left, longint right);
         out_frame_type entry;
         entry.left    = left[SAMPLE_BITS-1:0];
         entry.right   = right[SAMPLE_BITS-1:0];
         entry.run_end = 1'b0;
         expected_outputs.push_back(entry);
      endfunction

      // Work out every output one accepted frame causes.
      function void accept_frame(logic [SAMPLE_BITS-1:0] left_in,
                                 logic [SAMPLE_BITS-1:0] right_in,
                                 logic                   end_of_stream);
         bit              mono;
         longint          new_left;
         longint          new_right;
         longint          hold_right;
         longint unsigned step;
         int              first_idx;
         mono      = (channel_count == CHAN_MONO);
         new_left  = $signed(left_in);
         new_right = 0;
         if (!mono)
            new_right = $signed(right_in);
         step      = (step_ratio < MIN_STEP) ? MIN_STEP : longint'(step_ratio);
         first_idx = expected_outputs.size();

         if (primed) begin
            hold_right = mono ? 0 : held_right;
            while (read_position < ONE_POS) begin
               push_output(interpolate(held_left, new_left, read_position),
                           mono ? 0 : interpolate(hold_right, new_right, read_position));
               read_position += step;
            end
            read_position -= ONE_POS;
         end
         held_left  = new_left;
         held_right = new_right;
         primed     = 1'b1;

         // flush with the last frame held flat, then drop back to unprimed
         if (end_of_stream) begin
            while (read_position < ONE_POS) begin
               push_output(new_left, new_right);
               read_position += step;
            end
            read_position = 0;
            held_left     = 0;
            held_right    = 0;
            primed        = 1'b0;
         end

         if (expected_outputs.size() > first_idx)
            expected_outputs[expected_outputs.size()-1].run_end = 1'b1;
      endfunction

      function void check_output(logic [2*SAMPLE_BITS-1:0] data, logic run_end);
         out_frame_type want;
         if (expected_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output: left %h right %h last %b",
                        data[SAMPLE_BITS-1:0], data[2*SAMPLE_BITS-1:SAMPLE_BITS], run_end);
            return;
         end
         want = expected_outputs.pop_front();
         if (data[SAMPLE_BITS-1:0] !== want.left ||
             data[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.right ||
             run_end !== want.run_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"output mismatch: expected left %h right %h last %b, ",
                         "got left %h right %h last %b"},
                        want.left, want.right, want.run_end,
                        data[SAMPLE_BITS-1:0], data[2*SAMPLE_BITS-1:SAMPLE_BITS], run_end);
         end
      endfunction
   endclass

endpackage

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Top-level testbench: drives audio frames and register writes, checks outputs.
module tb_top;
   import lir_pkg::*;
   import lir_tb_pkg::*;

   localparam int DATA_BITS        = ((2*SAMPLE_BITS+7)/8)*8;
   localparam int RESET_CYCLES     = 11;
   localparam int SETTLE_CYCLES    = 400;
   localparam int CYCLE_LIMIT      = 4_000_000;
   localparam int RANDOM_PHASES    = 8;
   localparam int FRAMES_PER_PHASE = 45;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [DATA_BITS-1:0]     req_tdata = '0;   // left_sample, right_sample
   logic                     req_tlast = 1'b0; // end_of_stream

   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [DATA_BITS-1:0]     rsp_tdata;        // left_out, right_out
   logic                     rsp_tlast;        // last_of_run

   logic                     csr_wr_en = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wr_data = '0;

   resample_scoreboard audio_sb = new();

   int unsigned cycle_count = 0;
   int          burst_left = 1;
   bit          gaps_on = 1'b1;
   logic [31:0] stall_pattern = '1;
   logic [7:0]  pattern_pos = '0;

   linear_interp_resampler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: check every accepted output against the oldest expected one,
   // then pick the ready level for the next cycle. A fresh 32-bit stall pattern is
   // drawn whenever the position counter wraps: sometimes always ready, sometimes sparse.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         audio_sb.check_output(rsp_tdata[2*SAMPLE_BITS-1:0], rsp_tlast);
      if (pattern_pos == 8'd0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern <= '1;
            1:       stall_pattern <= $urandom | $urandom;
            2:       stall_pattern <= $urandom;
            default: stall_pattern <= ($urandom & $urandom) | 32'h8000_0001;
         endcase
      end
      rsp_tready  <= stall_pattern[pattern_pos[4:0]];
      pattern_pos <= pattern_pos + 8'd1;
   end

   // Drop valid and hold it low for a number of cycles (at least one).
   task automatic pause_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat ((cycles < 1) ? 1 : cycles) @(posedge clock);
   endtask

   // Offer one frame, hold it until accepted, then log it with the predictor.
   // Valid stays high between frames of a burst; gaps, if enabled, fall between bursts.
   task automatic send_frame(logic [SAMPLE_BITS-1:0] left, logic [SAMPLE_BITS-1:0] right,
                             logic eos);
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      audio_sb.accept_frame(left, right, eos);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on)
            pause_sender($urandom_range(1, 12));
      end
   endtask

   // Stop sending and wait until every expected output has come back.
   task automatic drain_results();
      pause_sender(1);
      while (audio_sb.outstanding() != 0)
         @(posedge clock);
   endtask

   // Drain, then give a frame that causes no output time to finish inside the block.
   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Pulse one register write; only called while the block is idle.
   task automatic write_register(logic [CSR_ADDR_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_addr    <= index;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      audio_sb.write_register(index, value);
      @(posedge clock);
   endtask

   // Next sample of a stream: extremes, silence, a small step or anything.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [SAMPLE_BITS-1:0] prev);
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3, 4, 5: return prev + 24'($urandom_range(0, 4095)) - 24'd2048;
         default: return 24'($urandom);
      endcase
   endfunction

   // One random configuration followed by mostly complete streams that end in
   // end of stream; the rest is noise with random end marks. Settle at the end.
   task automatic random_phase();
      logic [STEP_BITS-1:0]   step;
      logic [CHAN_BITS-1:0]   chans;
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] right;
      int                     frames_left;
      int                     run_len;
      left  = '0;
      right = '0;
      case ($urandom_range(0, 7))
         0:       step = STEP_LOW;
         1:       step = STEP_HIGH;
         2:       step = STEP_UNITY;
         3:       step = 20'($urandom_range(STEP_LOW, STEP_HIGH));
         4:       step = 20'($urandom_range(0, STEP_LOW - 1));       // raised to the minimum
         5:       step = 20'($urandom_range(STEP_HIGH + 1, STEP_ALL_ONES));
         default: step = 20'($urandom_range(STEP_LOW, 2 * STEP_UNITY));
      endcase
      case ($urandom_range(0, 5))
         0, 1:    chans = CHAN_MONO;
         2, 3:    chans = CHAN_STEREO;
         4:       chans = CHAN_ODD_ZERO;
         default: chans = CHAN_ODD_THREE;
      endcase
      write_register(CSR_STEP_RATIO, step);
      write_register(CSR_CHANNEL_COUNT, chans);
      gaps_on     = ($urandom_range(0, 3) != 0);
      frames_left = FRAMES_PER_PHASE;
      while (frames_left > 0) begin
         if ($urandom_range(0, 6) != 0) begin
            run_len = $urandom_range(2, 12);
            for (int i = 0; i < run_len; i++) begin
               left  = pick_sample(left);
               right = pick_sample(right);
               send_frame(left, right, i == run_len - 1);
            end
         end else begin
            run_len = $urandom_range(1, 4);
            for (int i = 0; i < run_len; i++)
               send_frame(24'($urandom), 24'($urandom), $urandom_range(0, 2) == 0);
         end
         frames_left -= run_len;
         // now and then hold off until the block has delivered everything
         if ($urandom_range(0, 15) == 0)
            drain_results();
      end
      settle();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration (unity step, stereo): prime, swing both channels
      // end to end, close the stream, then a lone frame that ends a stream.
      send_frame('0, '0, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
      send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
      settle();

      // Zero step is raised to the minimum: eight outputs per frame after the first,
      // sixteen on the end frame. Mono: right input ignored, right output zero.
      write_register(CSR_STEP_RATIO, 20'd0);
      write_register(CSR_CHANNEL_COUNT, CHAN_MONO);
      send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
      send_frame(SAMPLE_MIN, 24'h5A_5A5A, 1'b0);
      send_frame(24'd1, 24'hFF_FFFF, 1'b0);
      send_frame(24'hFF_FFFF, 24'd1, 1'b1);
      settle();

      // Step far above its range: frames are skipped, the end frame may flush
      // nothing. Channel code three acts as stereo.
      write_register(CSR_STEP_RATIO, STEP_ALL_ONES);
      write_register(CSR_CHANNEL_COUNT, CHAN_ODD_THREE);
      send_frame(24'h12_3456, 24'hED_CBA9, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_frame(24'hAA_AAAA, 24'h55_5555, 1'b0);
      send_frame(24'h55_5555, 24'hAA_AAAA, 1'b0);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_frame(24'h00_0F0F, 24'hF0_F000, 1'b1);
      settle();

      // Top of the step range with channel code zero; writes to unused
      // indexes must leave both registers alone.
      write_register(CSR_STEP_RATIO, STEP_HIGH);
      write_register(CSR_CHANNEL_COUNT, CHAN_ODD_ZERO);
      write_register(CSR_SPARE_LOW, STEP_ALL_ONES);
      write_register(CSR_SPARE_HIGH, 20'd1);
      send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
      send_frame(24'h80_0001, 24'h7F_FFFE, 1'b0);
      send_frame(24'h00_0001, 24'hFF_FFFF, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
      settle();

      // One below the minimum step, stereo.
      write_register(CSR_STEP_RATIO, STEP_LOW - 20'd1);
      write_register(CSR_CHANNEL_COUNT, CHAN_STEREO);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++)
         random_phase();

      // random_phase already settled; any stray output would have been flagged
      if (audio_sb.mismatches == 0 && audio_sb.outstanding() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[linear_interp_resampler.f]
rtl/lir_pkg.sv
rtl/lir_lerp.sv
rtl/lir_seq.sv
rtl/linear_interp_resampler.sv
tb/sv/lir_tb_pkg.sv
tb/sv/tb_top.sv
